// ===== hdl/nearest_waypoint_lookahead_macros.svh =====
// Assertion macros for the nearest waypoint block
`ifndef NEAREST_WAYPOINT_LOOKAHEAD_MACROS_SVH
`define NEAREST_WAYPOINT_LOOKAHEAD_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset
`define NWL_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("nwl assertion failed");
// Check that a trigger implies a condition in the cycle after it
`define NWL_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
    else $error("nwl assertion failed");
`else
`define NWL_ASSERT(lbl, clk, rstn, cond)
`define NWL_ASSERT_NEXT(lbl, clk, rstn, trig, cond)
`endif
`endif

// ===== hdl/nwl_pkg.sv =====
package nwl_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIST_W  = 51;
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned LA_W    = 10;
  localparam logic [LA_W-1:0] LOOKAHEAD_RESET = 10'd30;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatStored  = 2'd1,
    StatFull    = 2'd2,
    StatEmpty   = 2'd3
  } status_e;

  // Scan word handed from cell to cell
  typedef struct packed {
    logic                found;
    logic [DIST_W-1:0]   best_d;
    logic [IDX_W-1:0]    best;
    logic [IDX_W-1:0]    tgt;
    logic [COORD_W-1:0]  tx;
    logic [COORD_W-1:0]  ty;
    logic [IDX_W-1:0]    tidx;
  } word_t;

endpackage

// ===== hdl/nwl_in_if.sv =====
interface nwl_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        start_new;
  logic [23:0] pos_x;
  logic [23:0] pos_y;
  modport source (output valid, kind, start_new, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, start_new, pos_x, pos_y, output ready);
endinterface

// ===== hdl/nwl_out_if.sv =====
interface nwl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] target_x;
  logic [23:0] target_y;
  logic [9:0]  target_index;
  logic [9:0]  nearest_index;
  modport source (output valid, status, target_x, target_y, target_index, nearest_index,
                  input ready);
  modport sink   (input valid, status, target_x, target_y, target_index, nearest_index,
                  output ready);
endinterface

// ===== hdl/nwl_cell.sv =====
module nwl_cell #(
  parameter int unsigned IW       = 10,
  parameter int unsigned CW       = 11,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IW-1:0]        wr_idx_i,
  input  logic [23:0]          wr_x_i,
  input  logic [23:0]          wr_y_i,
  input  logic [23:0]          q_x_i,
  input  logic [23:0]          q_y_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic [9:0]           la_i,
  input  nwl_pkg::word_t       w_i,
  output nwl_pkg::word_t       w_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);
  localparam logic [nwl_pkg::IDX_W-1:0] MY_IDX_W = nwl_pkg::IDX_W'(CELL_IDX);

  logic [23:0]        pt_x_q, pt_y_q;
  logic signed [24:0] dx, dy;
  logic signed [49:0] px, py;
  logic [49:0]        sqx_q, sqy_q;
  logic [nwl_pkg::DIST_W-1:0] d_q;
  logic [nwl_pkg::IDX_W-1:0]  cnt_w, ntgt;
  logic active, take, last, cap;
  nwl_pkg::word_t w_d, w_q;

  // Store this cell's waypoint
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == MY_IDX)) begin
      pt_x_q <= wr_x_i;
      pt_y_q <= wr_y_i;
    end
  end

  // Square the offsets, then sum
  assign dx = $signed({pt_x_q[23], pt_x_q}) - $signed({q_x_i[23], q_x_i});
  assign dy = $signed({pt_y_q[23], pt_y_q}) - $signed({q_y_i[23], q_y_i});
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk_i) begin
    sqx_q <= unsigned'(px);
    sqy_q <= unsigned'(py);
    d_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  // Compare against the passing word and capture the target point
  assign cnt_w  = nwl_pkg::IDX_W'(cnt_i);
  assign active = MY_IDX_W < cnt_w;
  assign last   = (MY_IDX_W + nwl_pkg::IDX_W'(1)) == cnt_w;
  assign take   = active && (!w_i.found || (d_q < w_i.best_d));
  assign ntgt   = take ? (MY_IDX_W + nwl_pkg::IDX_W'(la_i)) : w_i.tgt;
  assign cap    = active && ((ntgt == MY_IDX_W) || (last && (ntgt > MY_IDX_W)));

  always_comb begin
    w_d = w_i;
    if (take) begin
      w_d.found  = 1'b1;
      w_d.best_d = d_q;
      w_d.best   = MY_IDX_W;
    end
    w_d.tgt = ntgt;
    if (cap) begin
      w_d.tx   = pt_x_q;
      w_d.ty   = pt_y_q;
      w_d.tidx = MY_IDX_W;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule

// ===== hdl/nearest_waypoint_lookahead.sv =====
// Load: the result is registered in the cycle after accept. Query on an empty path: likewise.
// Query: states StSq and StSum wait while every cell squares and then sums its
// offsets; in StScan the scan word walks the full row of cells, one cell per cycle.
// One item in flight at a time.
// Reset clears the point count, control state and sets lookahead to 30;
// stored waypoints are not cleared.
`include "nearest_waypoint_lookahead_macros.svh"
module nearest_waypoint_lookahead #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [9:0]   cfg_wdata_i,
  nwl_in_if.sink       in_i,
  nwl_out_if.source    out_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StSq   = 4'b0010,
    StSum  = 4'b0100,
    StScan = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, scan_q, scan_d;
  logic [9:0] la_q;
  logic [23:0] qx_q, qy_q;
  logic in_ready, in_acc, wr_en, res_en, oval_q, oval_d;
  logic [IW-1:0] wr_idx;
  nwl_pkg::status_e res_st, st_q;
  logic [23:0] res_x, res_y, tx_q, ty_q;
  logic [9:0] res_ti, res_ni, ti_q, ni_q;
  nwl_pkg::word_t w [MAX_POINTS+1];

  assign in_ready  = (state_q == StIdle) && (!oval_q || out_o.ready);
  assign in_acc    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Sequence loads and queries
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    wr_en   = 1'b0;
    wr_idx  = cnt_q[IW-1:0];
    res_en  = 1'b0;
    res_st  = nwl_pkg::StatOk;
    res_x   = '0;
    res_y   = '0;
    res_ti  = '0;
    res_ni  = '0;
    oval_d  = oval_q && !out_o.ready;
    unique case (state_q)
      StIdle: begin
        if (in_acc && !in_i.kind) begin
          res_en = 1'b1;
          if (in_i.start_new) begin
            wr_en  = 1'b1;
            wr_idx = '0;
            cnt_d  = CW'(1);
            res_st = nwl_pkg::StatStored;
          end else if (cnt_q == MAX_CNT) begin
            res_st = nwl_pkg::StatFull;
          end else begin
            wr_en  = 1'b1;
            cnt_d  = cnt_q + CW'(1);
            res_st = nwl_pkg::StatStored;
          end
        end else if (in_acc) begin
          if (cnt_q == '0) begin
            res_en = 1'b1;
            res_st = nwl_pkg::StatEmpty;
          end else begin
            state_d = StSq;
          end
        end
      end
      StSq:  state_d = StSum;
      StSum: begin
        state_d = StScan;
        scan_d  = '0;
      end
      StScan: begin
        scan_d = scan_q + CW'(1);
        if (scan_q == MAX_CNT) begin
          state_d = StIdle;
          res_en  = 1'b1;
          res_x   = w[MAX_POINTS].tx;
          res_y   = w[MAX_POINTS].ty;
          res_ti  = w[MAX_POINTS].tidx[9:0];
          res_ni  = w[MAX_POINTS].best[9:0];
        end
      end
      default: state_d = StIdle;
    endcase
    if (res_en) oval_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      scan_q  <= '0;
      oval_q  <= 1'b0;
      la_q    <= nwl_pkg::LOOKAHEAD_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      oval_q  <= oval_d;
      if (cfg_we_i) la_q <= cfg_wdata_i;
    end
  end

  // Hold the query position and the result word
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.kind) begin
      qx_q <= in_i.pos_x;
      qy_q <= in_i.pos_y;
    end
    if (res_en) begin
      st_q <= res_st;
      tx_q <= res_x;
      ty_q <= res_y;
      ti_q <= res_ti;
      ni_q <= res_ni;
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.status        = st_q;
  assign out_o.target_x      = tx_q;
  assign out_o.target_y      = ty_q;
  assign out_o.target_index  = ti_q;
  assign out_o.nearest_index = ni_q;

  // Row of cells, seeded with an empty word
  assign w[0] = '0;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    nwl_cell #(.IW(IW), .CW(CW), .CELL_IDX(g)) u_cell (
      .clk_i    (clk_i),
      .wr_en_i  (wr_en),
      .wr_idx_i (wr_idx),
      .wr_x_i   (in_i.pos_x),
      .wr_y_i   (in_i.pos_y),
      .q_x_i    (qx_q),
      .q_y_i    (qy_q),
      .cnt_i    (cnt_q),
      .la_i     (la_q),
      .w_i      (w[g]),
      .w_o      (w[g+1])
    );
  end

  `NWL_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= MAX_CNT)
  `NWL_ASSERT(a_busy_no_acc, clk_i, rst_ni, !((state_q != StIdle) && in_acc))
  `NWL_ASSERT_NEXT(a_load_nonempty, clk_i, rst_ni, in_acc && !in_i.kind, cnt_q != '0)
  `NWL_ASSERT_NEXT(a_scan_done, clk_i, rst_ni, (state_q == StScan) && (scan_q == MAX_CNT),
                   oval_q && (st_q == nwl_pkg::StatOk))

endmodule
